/* rtl/hufd_pkg.sv */
// ----------------------------------------------------------------------------
// hufd_pkg
// shared types and constants of the table driven prefix code decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hufd_pkg;

  localparam int unsigned MaxEntriesDef = 256;
  localparam int unsigned MaxCodeLenDef = 8;
  localparam int unsigned MaxOut        = 15;
  localparam int unsigned BufW          = 16;
  localparam int unsigned CntW          = 5;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 9;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNumEntries = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPadBits    = 2'd1;

  // request kinds
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqData = 1'b1;

  typedef struct packed {
    logic [7:0] sym;
    logic [7:0] code;
    logic [3:0] len;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic       req_type;
    logic [7:0] idx;
    entry_t     entry;
    logic [7:0] data;
  } item_t;

  // back end status seen by the top level checks
  typedef struct packed {
    logic          idle;
    logic          pend_vld;
    logic [CntW-1:0] cnt;
  } back_status_t;

endpackage

`default_nettype wire

/* rtl/hufd_ram.sv */
// ----------------------------------------------------------------------------
// hufd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/hufd_front.sv */
// ----------------------------------------------------------------------------
// hufd_front
// accepts request transfers and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire hufd_pkg::item_t item_i,
  output logic                q_valid_o,
  output hufd_pkg::item_t     q_item_o,
  input  wire logic           q_pop_i
);
  import hufd_pkg::*;

  item_t      slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/hufd_back.sv */
// ----------------------------------------------------------------------------
// hufd_back
// table store, bit buffer and sequential codeword search
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_back #(
  parameter int unsigned MaxEntries = hufd_pkg::MaxEntriesDef,
  parameter int unsigned MaxCodeLen = hufd_pkg::MaxCodeLenDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [8:0]           num_entries_i,
  input  wire logic [2:0]           pad_bits_i,
  input  wire logic                 q_valid_i,
  input  wire hufd_pkg::item_t      q_item_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                symbol_o,
  output logic                      last_o,
  output hufd_pkg::back_status_t    status_o
);
  import hufd_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxEntries);
  localparam int unsigned IdxW  = AddrW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NEXT,
    S_CMP,
    S_FLUSH
  } state_e;

  state_e          state_q;
  logic [BufW-1:0] buf_q;
  logic [CntW-1:0] cnt_q;
  logic            first_q;
  logic [3:0]      nres_q;
  logic [IdxW-1:0] idx_q;
  logic            pend_vld_q;
  logic [7:0]      pend_sym_q;
  logic            out_vld_q;
  logic [7:0]      out_sym_q;
  logic            out_last_q;

  entry_t          rd_entry;
  logic [8:0]      limit;
  logic            slot_free;
  logic            hit;
  logic [7:0]      prefix;
  logic [7:0]      code_mask;
  logic            ram_we;
  logic [BufW-1:0] buf_base;
  logic [CntW-1:0] cnt_base;
  logic            out_load;

  hufd_ram #(
    .Width (EntryW),
    .Depth (MaxEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_item_i.idx[AddrW-1:0]),
    .wdata_i (q_item_i.entry),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rd_entry)
  );

  assign q_pop_o   = q_valid_i && (state_q == S_IDLE);
  assign ram_we    = q_pop_o && (q_item_i.req_type == ReqLoad) &&
                     (9'(q_item_i.idx) < 9'(MaxEntries));
  assign limit     = (num_entries_i > 9'(MaxEntries)) ? 9'(MaxEntries) : num_entries_i;
  assign slot_free = !out_vld_q || !out_stall_i;

  // output register takes the held symbol on a later hit or at the flush
  assign out_load  = slot_free && (((state_q == S_CMP) && hit && pend_vld_q) ||
                                   (state_q == S_FLUSH));

  // if more than one byte of stale bits is left, the whole buffer is cleared before the next byte lands
  assign buf_base = (cnt_q > CntW'(8)) ? '0 : buf_q;
  assign cnt_base = (cnt_q > CntW'(8)) ? '0 : cnt_q;

  always_comb begin
    prefix    = 8'(buf_q[15:8] >> (4'd8 - rd_entry.len));
    code_mask = 8'((9'h1 << rd_entry.len) - 9'h1);
    hit = (rd_entry.len != 4'd0) && (32'(rd_entry.len) <= MaxCodeLen) &&
          (CntW'(rd_entry.len) <= cnt_q) && (prefix == (rd_entry.code & code_mask));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      buf_q      <= '0;
      cnt_q      <= '0;
      first_q    <= 1'b1;
      nres_q     <= '0;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      pend_sym_q <= '0;
      out_sym_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      out_vld_q <= out_load || (out_vld_q && out_stall_i);
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o && (q_item_i.req_type == ReqData)) begin
            if (first_q) begin
              buf_q   <= BufW'({q_item_i.data, 8'h00} << pad_bits_i);
              cnt_q   <= CntW'(8) - CntW'(pad_bits_i);
              first_q <= 1'b0;
            end else begin
              buf_q <= buf_base | BufW'({q_item_i.data, 8'h00} >> cnt_base);
              cnt_q <= cnt_base + CntW'(8);
            end
            nres_q  <= '0;
            idx_q   <= '0;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if ((cnt_q == '0) || (nres_q == 4'(MaxOut)) || (9'(idx_q) >= limit)) begin
            state_q <= pend_vld_q ? S_FLUSH : S_IDLE;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (!hit) begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= S_NEXT;
          end else if (!pend_vld_q || slot_free) begin
            if (pend_vld_q) begin
              out_sym_q  <= pend_sym_q;
              out_last_q <= 1'b0;
            end
            pend_vld_q <= 1'b1;
            pend_sym_q <= rd_entry.sym;
            buf_q      <= buf_q << rd_entry.len;
            cnt_q      <= cnt_q - CntW'(rd_entry.len);
            nres_q     <= nres_q + 4'd1;
            idx_q      <= '0;
            state_q    <= S_NEXT;
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            out_sym_q  <= pend_sym_q;
            out_last_q <= 1'b1;
            pend_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_vld_q;
  assign symbol_o          = out_sym_q;
  assign last_o            = out_last_q;
  assign status_o.idle     = (state_q == S_IDLE);
  assign status_o.pend_vld = pend_vld_q;
  assign status_o.cnt      = cnt_q;

endmodule

`default_nettype wire

/* rtl/huffman_table_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_table_decoder
// prefix code decoder driven by a loadable symbol table
// ----------------------------------------------------------------------------
// Load transfers (req_type 0) write one table entry in the back end. Data
// transfers (req_type 1) append a byte to the bit buffer, after which the
// table is probed in index order, each entry through the S_NEXT state
// (address) and the S_CMP state (registered ram read and compare), until the
// first matching codeword is found; the scan restarts from entry zero for
// every symbol. A byte that ends without a further match takes a final scan
// over n entries (n the lesser of num_entries and MAX_ENTRIES), then S_NEXT
// closes the scan and S_FLUSH presents its last symbol. The table ram has a
// single read port. A two entry queue decouples the input from the back end,
// and the output register lets the back end keep scanning while a symbol
// waits. The table has no reset; entries must be loaded before data that
// could reach them arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_table_decoder #(
  parameter int unsigned MAX_ENTRIES  = hufd_pkg::MaxEntriesDef,
  parameter int unsigned MAX_CODE_LEN = hufd_pkg::MaxCodeLenDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [hufd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [hufd_pkg::CfgDataW-1:0]  cfg_data_i,
  // request channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           req_type_i,
  input  wire logic [7:0]                     entry_index_i,
  input  wire logic [7:0]                     entry_symbol_i,
  input  wire logic [7:0]                     entry_code_i,
  input  wire logic [3:0]                     entry_length_i,
  input  wire logic [7:0]                     data_byte_i,
  // symbol channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [7:0]                          symbol_o,
  output logic                                last_o
);
  import hufd_pkg::*;

  logic [8:0]   num_entries_q;
  logic [2:0]   pad_bits_q;
  item_t        in_item;
  item_t        q_item;
  logic         q_valid;
  logic         q_pop;
  back_status_t status;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_entries_q <= 9'd256;
      pad_bits_q    <= 3'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgNumEntries: num_entries_q <= cfg_data_i[8:0];
        CfgPadBits:    pad_bits_q    <= cfg_data_i[2:0];
        default:       ;
      endcase
    end
  end

  // pack the request fields
  assign in_item.req_type    = req_type_i;
  assign in_item.idx         = entry_index_i;
  assign in_item.entry.sym   = entry_symbol_i;
  assign in_item.entry.code  = entry_code_i;
  assign in_item.entry.len   = entry_length_i;
  assign in_item.data        = data_byte_i;

  hufd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  hufd_back #(
    .MaxEntries (MAX_ENTRIES),
    .MaxCodeLen (MAX_CODE_LEN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_entries_i (num_entries_q),
    .pad_bits_i    (pad_bits_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .symbol_o      (symbol_o),
    .last_o        (last_o),
    .status_o      (status)
  );

  // the buffer never holds more than two bytes
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.cnt <= CntW'(16))
    else $error("bit count overflow");

  // a held symbol never outlives the byte that produced it
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.idle && status.pend_vld))
    else $error("pending symbol left behind");

  // an accepted request is queued or already taken by the back end
  a_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> q_valid || !status.idle)
    else $error("request lost");

endmodule

`default_nettype wire
